// ===== sv/ric_pkg.sv =====
// ----------------------------------------------------------------------------
// ric_pkg - shared types for ring interpolation coefficients
// payload structs, mode codes, pipeline structs and fixed-point helpers
// ----------------------------------------------------------------------------
package ric_pkg;

    typedef logic signed [31:0] q16_t;
    typedef logic signed [32:0] diff_t;
    typedef logic signed [39:0] wide_t;

    localparam int DIV_STAGES = 32;

    localparam logic [2:0] MODE_LINEAR  = 3'd0;
    localparam logic [2:0] MODE_QUAD    = 3'd1;
    localparam logic [2:0] MODE_SPLINE  = 3'd2;
    localparam logic [2:0] MODE_HERMITE = 3'd3;
    localparam logic [2:0] MODE_PCHIP   = 3'd4;

    typedef struct packed {
        q16_t       sample_0;
        q16_t       sample_1;
        q16_t       sample_2;
        q16_t       sample_3;
        q16_t       sample_4;
        q16_t       sample_5;
        q16_t       sample_6;
        q16_t       sample_7;
        logic [2:0] center_index;
    } in_item_t;

    typedef struct packed {
        q16_t coeff_0;
        q16_t coeff_1;
        q16_t coeff_2;
        q16_t coeff_3;
        q16_t coeff_4;
    } out_item_t;

    // centre and neighbours as the pipeline carries them
    typedef struct packed {
        q16_t       y0;
        q16_t       y1;
        q16_t       y2;
        q16_t       y6;
        q16_t       y7;
        logic       even;
        logic [2:0] mode;
    } ring_t;

    typedef struct packed {
        logic hen;
        logic hneg;
        q16_t lim;
    } div_meta_t;

    typedef struct packed {
        logic [32:0] r;
        logic [31:0] pl;
        logic [31:0] q;
        logic [32:0] s;
        div_meta_t   meta;
    } div_st_t;

    function automatic q16_t sat32(input wide_t v);
        q16_t res;
        if (v > wide_t'(32'sh7fffffff))
            res = 32'sh7fffffff;
        else if (v < -wide_t'(40'sh80000000))
            res = 32'sh80000000;
        else
            res = v[31:0];
        return res;
    endfunction

    function automatic wide_t half_floor(input wide_t v);
        return v >>> 1;
    endfunction

    function automatic wide_t wabs(input wide_t v);
        return v[39] ? -v : v;
    endfunction

    // one-sided end slope with monotone limiter, p is the near difference
    function automatic wide_t lim_fn(input wide_t p, input wide_t q);
        wide_t p3;
        wide_t a;
        wide_t res;
        p3 = (p <<< 1) + p;
        a  = half_floor(p3 - q);
        if (a == 0 || p == 0 || a[39] != p[39])
            res = '0;
        else if ((q == 0 || p[39] != q[39]) && wabs(a) > wabs(p3))
            res = p3;
        else
            res = a;
        return res;
    endfunction

endpackage

// ===== sv/ric_div.sv =====
// ----------------------------------------------------------------------------
// ric_div - pipelined restoring divider
// one quotient bit per stage, quotient known to fit 32 bits
// ----------------------------------------------------------------------------
module ric_div
    import ric_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] dividend,
    input  logic [32:0] divisor,
    input  div_meta_t   meta_in,
    output logic [31:0] quot,
    output logic [32:0] rem,
    output logic [32:0] divisor_out,
    output div_meta_t   meta_out
);

    div_st_t st [0:DIV_STAGES];

    // high half is already below the divisor when the quotient fits
    assign st[0] = '{r: {1'b0, dividend[63:32]}, pl: dividend[31:0], q: '0,
                     s: divisor, meta: meta_in};

    genvar i;
    generate
        for (i = 0; i < DIV_STAGES; i++)
        begin : g_stage
            div_st_t     st_next;
            logic [33:0] trial;
            logic        ge;

            always_comb
            begin
                trial   = {st[i].r, st[i].pl[31]};
                ge      = trial >= {1'b0, st[i].s};
                st_next = st[i];
                st_next.r  = ge ? 33'(trial - {1'b0, st[i].s}) : trial[32:0];
                st_next.pl = {st[i].pl[30:0], 1'b0};
                st_next.q  = {st[i].q[30:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    st[i+1] <= st_next;
            end
        end
    endgenerate

    assign quot        = st[DIV_STAGES].q;
    assign rem         = st[DIV_STAGES].r;
    assign divisor_out = st[DIV_STAGES].s;
    assign meta_out    = st[DIV_STAGES].meta;

endmodule

// ===== sv/ric_lane.sv =====
// ----------------------------------------------------------------------------
// ric_lane - slope core for one side of the centre
// monotone limiter and harmonic mean through multiplier and divider
// ----------------------------------------------------------------------------
module ric_lane
    import ric_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  diff_t ha,
    input  diff_t hb,
    input  logic  even,
    output q16_t  harm,
    output q16_t  lim
);

    div_meta_t   m1_reg, m1_next;
    logic [31:0] ma_reg, mb_reg;
    logic [31:0] ma_next, mb_next;
    div_meta_t   m2_reg;
    logic [63:0] prod_reg;
    logic [32:0] sum_reg;

    logic [31:0] quot;
    logic [32:0] rem;
    logic [32:0] div_s;
    div_meta_t   mo;
    logic        rnd;
    logic [32:0] q2;
    wide_t       hw;

    always_comb
    begin
        m1_next.hen  = (ha != 0) && (hb != 0) && (ha[32] == hb[32]);
        m1_next.hneg = ha[32];
        // odd centre swaps the limiter's near and far differences
        m1_next.lim  = even ? sat32(lim_fn(wide_t'(ha), wide_t'(hb)))
                            : sat32(lim_fn(wide_t'(hb), wide_t'(ha)));
        ma_next = ha[32] ? 32'(-ha) : ha[31:0];
        mb_next = hb[32] ? 32'(-hb) : hb[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg   <= m1_next;
            ma_reg   <= ma_next;
            mb_reg   <= mb_next;
            m2_reg   <= m1_reg;
            prod_reg <= ma_reg * mb_reg;
            sum_reg  <= {1'b0, ma_reg} + {1'b0, mb_reg};
        end
    end

    ric_div u_div (
        .clk         (clk),
        .en          (en),
        .dividend    (prod_reg),
        .divisor     (sum_reg),
        .meta_in     (m2_reg),
        .quot        (quot),
        .rem         (rem),
        .divisor_out (div_s),
        .meta_out    (mo)
    );

    always_comb
    begin
        rnd = {rem, 1'b0} >= {1'b0, div_s};
        q2  = {quot, 1'b0} + {32'b0, rnd};
        hw  = mo.hneg ? -wide_t'({7'b0, q2}) : wide_t'({7'b0, q2});
    end

    assign harm = mo.hen ? sat32(hw) : '0;
    assign lim  = mo.lim;

endmodule

// ===== sv/ring_interpolation_coefficients_top.sv =====
// ----------------------------------------------------------------------------
// ring_interpolation_coefficients_top - interpolation coefficients on a ring
// five saturated Q16.16 coefficients per item in the configured mode
// ----------------------------------------------------------------------------
// pipeline: the input register loads at the transfer edge, then two lane
//   stages, 32 divider stages and the output register
// throughput: one item per cycle unless the output is held; the
//   harmonic-mean divider is fully pipelined
// the whole pipeline holds while a result waits and out_ready is low
// reset: valid bits and mode_reg clear at once, payload registers do not
module ring_interpolation_coefficients_top
    import ric_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [2:0] cfg_data,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam int DEPTH = DIV_STAGES + 2;

    logic [2:0] mode_reg;
    logic       adv;

    // ring selection at the input
    q16_t  ys [0:7];
    ring_t ring_next;
    ring_t s0_reg;
    logic  v0_reg;

    // lane operands, side 0 walks up the ring and side 1 walks down
    diff_t ha0, hb0, ha1, hb1;
    q16_t  harm0, lim0, harm1, lim1;

    // delay line that keeps the centre data aligned with the lanes
    ring_t dly_reg [1:DEPTH];
    logic  vld_reg [1:DEPTH];

    ring_t     r;
    wide_t     y0, y1, y2, y6, y7;
    wide_t     ta, tb;
    wide_t     c0, c1, c2, c3, c4;
    out_item_t res_next;
    logic      out_valid_reg;
    out_item_t out_data_reg;

    // stall everything while the output is held
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_LINEAR;
        else if (cfg_we)
            mode_reg <= cfg_data;
    end

    always_comb
    begin
        ys[0] = in_data.sample_0;
        ys[1] = in_data.sample_1;
        ys[2] = in_data.sample_2;
        ys[3] = in_data.sample_3;
        ys[4] = in_data.sample_4;
        ys[5] = in_data.sample_5;
        ys[6] = in_data.sample_6;
        ys[7] = in_data.sample_7;
        ring_next.y0   = ys[in_data.center_index];
        ring_next.y1   = ys[3'(in_data.center_index + 3'd1)];
        ring_next.y2   = ys[3'(in_data.center_index + 3'd2)];
        ring_next.y6   = ys[3'(in_data.center_index + 3'd6)];
        ring_next.y7   = ys[3'(in_data.center_index + 3'd7)];
        ring_next.even = !in_data.center_index[0];
        ring_next.mode = mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (adv)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s0_reg <= ring_next;
    end

    always_comb
    begin
        if (s0_reg.even)
        begin
            ha0 = diff_t'(s0_reg.y1) - diff_t'(s0_reg.y0);
            hb0 = diff_t'(s0_reg.y2) - diff_t'(s0_reg.y1);
            ha1 = diff_t'(s0_reg.y7) - diff_t'(s0_reg.y0);
            hb1 = diff_t'(s0_reg.y6) - diff_t'(s0_reg.y7);
        end
        else
        begin
            ha0 = diff_t'(s0_reg.y0) - diff_t'(s0_reg.y7);
            hb0 = diff_t'(s0_reg.y1) - diff_t'(s0_reg.y0);
            ha1 = diff_t'(s0_reg.y0) - diff_t'(s0_reg.y1);
            hb1 = diff_t'(s0_reg.y7) - diff_t'(s0_reg.y0);
        end
    end

    ric_lane u_lane0 (
        .clk  (clk),
        .en   (adv),
        .ha   (ha0),
        .hb   (hb0),
        .even (s0_reg.even),
        .harm (harm0),
        .lim  (lim0)
    );

    ric_lane u_lane1 (
        .clk  (clk),
        .en   (adv),
        .ha   (ha1),
        .hb   (hb1),
        .even (s0_reg.even),
        .harm (harm1),
        .lim  (lim1)
    );

    genvar k;
    generate
        for (k = 1; k <= DEPTH; k++)
        begin : g_dly
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (adv)
                    vld_reg[k] <= (k == 1) ? v0_reg : vld_reg[k-1];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                    dly_reg[k] <= (k == 1) ? s0_reg : dly_reg[k-1];
            end
        end
    endgenerate

    // merging stage: pick per mode, full precision until the final saturation
    always_comb
    begin
        r  = dly_reg[DEPTH];
        y0 = wide_t'(r.y0);
        y1 = wide_t'(r.y1);
        y2 = wide_t'(r.y2);
        y6 = wide_t'(r.y6);
        y7 = wide_t'(r.y7);
        ta = '0;
        tb = '0;
        c0 = '0;
        c1 = '0;
        c2 = '0;
        c3 = '0;
        c4 = '0;
        unique case (r.mode)
            MODE_LINEAR:
            begin
            end
            MODE_QUAD:
            begin
                c0 = y0;
                if (r.even)
                begin
                    ta = half_floor(y2 + y0 - (y1 <<< 1));
                    tb = half_floor(y6 + y0 - (y7 <<< 1));
                    c2 = ta;
                    c1 = y1 - y0 - ta;
                    c4 = tb;
                    c3 = y7 - y0 - tb;
                end
                else
                begin
                    ta = half_floor(y1 + y7 - (y0 <<< 1));
                    c2 = ta;
                    c4 = ta;
                    c1 = y0 - y7 + ta;
                    c3 = y0 - y1 + ta;
                end
            end
            MODE_SPLINE:
            begin
                if (r.even)
                begin
                    ta = y0 - (y1 <<< 1) + y2;
                    tb = y0 - (y7 <<< 1) + y6;
                    c1 = half_floor((ta <<< 1) + ta);
                    c3 = half_floor((tb <<< 1) + tb);
                end
                else
                begin
                    ta = y7 - (y0 <<< 1) + y1;
                    c0 = half_floor((ta <<< 1) + ta);
                    c2 = c0;
                end
            end
            MODE_HERMITE:
            begin
                if (r.even)
                begin
                    c0 = y1 - y0;
                    c1 = half_floor(y2 - y0);
                    c2 = y7 - y0;
                    c3 = half_floor(y6 - y0);
                end
                else
                begin
                    c0 = half_floor(y1 - y7);
                    c1 = y1 - y0;
                    c2 = -c0;
                    c3 = y7 - y0;
                end
            end
            default:
            begin
                // pchip, also taken by the unused mode codes
                if (r.even)
                begin
                    c0 = wide_t'(lim0);
                    c1 = wide_t'(harm0);
                    c2 = wide_t'(lim1);
                    c3 = wide_t'(harm1);
                end
                else
                begin
                    c0 = wide_t'(harm0);
                    c1 = wide_t'(lim0);
                    c2 = wide_t'(harm1);
                    c3 = wide_t'(lim1);
                end
            end
        endcase
        res_next.coeff_0 = sat32(c0);
        res_next.coeff_1 = sat32(c1);
        res_next.coeff_2 = sat32(c2);
        res_next.coeff_3 = sat32(c3);
        res_next.coeff_4 = sat32(c4);
    end

    ring_t out_ring_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= vld_reg[DEPTH];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= res_next;
            out_ring_reg <= r;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // linear mode gives an all-zero transfer
    a_linear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_ring_reg.mode == MODE_LINEAR |->
            out_data_reg == '0)
        else $error("linear mode result not zero");

    // coefficient 4 is only used by the quadratic form
    a_coeff4_quad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_ring_reg.mode != MODE_QUAD |->
            out_data_reg.coeff_4 == '0)
        else $error("coefficient 4 set outside quadratic mode");

    // a held result stays offered and unchanged
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_data_reg))
        else $error("result changed while held");

endmodule
